// ===== hdl/oah_pkg.sv =====
// shared constants, types and the arctangent table builder for the orientation histogram
// no dependencies
package oah_pkg;

  localparam int POLAR_BINS_DEF  = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int CORDIC_STEPS = 32;
  localparam int ANG_W        = 48;   // signed q40 radians
  localparam int XY_W         = 40;   // cordic x/y datapath
  localparam int DIV_W        = 64;   // bin divider remainder

  localparam logic [63:0]      PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [ANG_W-1:0] PI_Q40 = ANG_W'(PI_Q60 >> 20);

  typedef logic [CORDIC_STEPS-1:0][ANG_W-1:0] arc_tab_t;

  // atan(2^-i) in q40, from the alternating series in q60
  function automatic arc_tab_t build_arc_tab();
    arc_tab_t    tab;
    logic [63:0] v;
    logic [63:0] t;
    int          e;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      v = '0;
      if (i == 0) begin
        v = PI_Q60 / 4;
      end else begin
        for (int k = 0; k < 64; k++) begin
          e = 60 - i * (2 * k + 1);
          if (e >= 0) begin
            t = (64'd1 << e) / 64'(2 * k + 1);
            if ((k % 2) == 1) v = v - t;
            else              v = v + t;
          end
        end
      end
      tab[i] = ANG_W'(v >> 20);
    end
    return tab;
  endfunction

  localparam arc_tab_t ARC_TAB = build_arc_tab();

endpackage

// ===== hdl/oah_ram.sv =====
// generic single-port synchronous ram with registered read
// no dependencies
module oah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== hdl/orientation_angle_histogram.sv =====
// orientation angle histogram: polar/azimuth binning of unit vectors into a count ram
// depends on oah_pkg and oah_ram
// accumulate beat: the 16-step square root, then two cordic runs on one shared unit, each
//   a load plus 32 steps and then an angle state and a bin state; read beat: a ram read
//   state and a write-back state, ending in the result strobe; one beat at a time, busy is
//   high meanwhile and the next beat can be taken while the strobe is high
// reset: the count ram is cleared by a pass over all 2*POLAR_BINS^2 cells (512 at 16 bins) with
//   busy high; the frame counter clears at once; results cannot be stalled
module orientation_angle_histogram
  import oah_pkg::*;
#(
  parameter int POLAR_BINS  = POLAR_BINS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic signed [15:0] vec_x_i,
  input  logic signed [15:0] vec_y_i,
  input  logic signed [15:0] vec_z_i,
  input  logic               end_of_frame_i,
  input  logic [3:0]         read_polar_index_i,
  input  logic [4:0]         read_azimuth_index_i,
  output logic               result_valid_o,
  output logic [3:0]         polar_bin_o,
  output logic [4:0]         azimuth_bin_o,
  output logic [31:0]        cell_count_o,
  output logic [31:0]        frames_seen_o
);

  localparam int AZ_BINS = 2 * POLAR_BINS;
  localparam int CELLS   = POLAR_BINS * AZ_BINS;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int PW      = $clog2(POLAR_BINS);
  localparam int AW      = $clog2(AZ_BINS);
  localparam int QW      = AW + 1;     // quotient bits, room for the edge overshoot

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_SQRT, S_CORD, S_ANG, S_DIV, S_RD, S_WB
  } state_e;

  state_e state_q;

  // beat fields held for the whole run
  logic               mode_q, eof_q;
  logic signed [15:0] vx_q, vy_q, vz_q;

  // square root
  logic [31:0] sq_r_q, sq_res_q;
  logic [3:0]  sq_cnt_q;

  // shared cordic
  logic signed [XY_W-1:0]  cx_q, cy_q;
  logic signed [ANG_W-1:0] cz_q, base_q;
  logic [4:0]              step_q;
  logic                    az_q;        // 0 polar run, 1 azimuth run
  logic                    cord_loaded_q;
  logic                    hold_step;

  // bin stage
  logic [DIV_W-1:0] rem_q;

  logic [PW-1:0]     pbin_q;
  logic [AW-1:0]     abin_q;
  logic [ADDR_W-1:0] addr_q, clr_q;
  logic [31:0]       frame_q;

  // ram port
  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_addr;
  logic [COUNT_WIDTH-1:0] ram_wdata, ram_rdata;

  oah_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  logic accept;
  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // 2^30 - z^2, never negative for a 16-bit z
  logic signed [31:0] zsq;
  logic [31:0]        sq_rem0;
  assign zsq     = 32'(vec_z_i * vec_z_i);
  assign sq_rem0 = 32'h4000_0000 - 32'(zsq);

  // one square root step, trial bit 2^(30-2n)
  logic [31:0] sq_bit, sq_trial;
  assign sq_bit   = 32'd1 << (5'd30 - {sq_cnt_q, 1'b0});
  assign sq_trial = sq_res_q + sq_bit;

  // cordic load values: polar run takes (z, root), azimuth run (x, y),
  // folded into the right half plane
  logic signed [16:0]      ld_x, ld_y, ld_xf, ld_yf;
  logic signed [ANG_W-1:0] ld_base;
  always_comb begin
    if (!az_q) begin
      ld_x = 17'(vz_q);
      ld_y = {1'b0, sq_res_q[15:0]};
    end else begin
      ld_x = 17'(vx_q);
      ld_y = 17'(vy_q);
    end
    if (ld_x < 0) begin
      ld_xf   = -ld_x;
      ld_yf   = -ld_y;
      ld_base = (ld_y >= 0) ? $signed(PI_Q40) : -$signed(PI_Q40);
    end else begin
      ld_xf   = ld_x;
      ld_yf   = ld_y;
      ld_base = '0;
    end
  end

  logic signed [XY_W-1:0] ld_xs, ld_ys;
  assign ld_xs = XY_W'(ld_xf) <<< 20;
  assign ld_ys = XY_W'(ld_yf) <<< 20;

  // the first cordic cycle of each run is a load, after which 32 steps follow
  assign hold_step = (state_q == S_CORD && step_q == 5'd0 && !cord_loaded_q);

  // cordic vectoring step with floor shifts; y = 0 leaves everything as is
  logic signed [XY_W-1:0]  shx, shy;
  logic signed [ANG_W-1:0] arc;
  assign shx = cx_q >>> step_q;
  assign shy = cy_q >>> step_q;
  assign arc = $signed(ARC_TAB[step_q]);

  // angle and dividend, negative angles count as zero
  logic signed [ANG_W-1:0] ang;
  logic [DIV_W-1:0]        dividend;
  assign ang      = base_q + cz_q + (az_q ? $signed(PI_Q40) : ANG_W'(0));
  assign dividend = ang[ANG_W-1] ? '0 : DIV_W'(ang) * DIV_W'(POLAR_BINS);

  // bin = number of multiples of pi reached, compared against constant thresholds
  logic [QW-1:0] quo_c;
  always_comb begin
    quo_c = '0;
    for (int k = 1; k <= AZ_BINS; k++) begin
      if (rem_q >= DIV_W'(k) * DIV_W'(PI_Q40)) quo_c = QW'(k);
    end
  end

  // clamped bins from the quotient
  logic [PW-1:0] pbin_c;
  logic [AW-1:0] abin_c;
  assign pbin_c = (32'(quo_c) > 32'(POLAR_BINS - 1)) ? PW'(POLAR_BINS - 1) : PW'(quo_c);
  assign abin_c = (32'(quo_c) > 32'(AZ_BINS - 1))    ? AW'(AZ_BINS - 1)    : AW'(quo_c);

  // read mode cell, indices beyond the grid go to the last bin
  logic [PW-1:0] rd_p;
  logic [AW-1:0] rd_a;
  assign rd_p = (32'(read_polar_index_i) > 32'(POLAR_BINS - 1)) ?
                PW'(POLAR_BINS - 1) : PW'(read_polar_index_i);
  assign rd_a = (32'(read_azimuth_index_i) > 32'(AZ_BINS - 1)) ?
                AW'(AZ_BINS - 1) : AW'(read_azimuth_index_i);

  // saturating count update
  logic [COUNT_WIDTH-1:0] new_cnt, out_cnt;
  logic [63:0]            out_wide;
  assign new_cnt  = (&ram_rdata) ? ram_rdata : ram_rdata + COUNT_WIDTH'(1);
  assign out_cnt  = mode_q ? ram_rdata : new_cnt;
  assign out_wide = 64'(out_cnt);

  assign ram_we    = (state_q == S_CLR) || (state_q == S_WB && !mode_q);
  assign ram_addr  = (state_q == S_CLR) ? clr_q : addr_q;
  assign ram_wdata = (state_q == S_CLR) ? '0 : new_cnt;

  // control state and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLR;
      clr_q          <= '0;
      sq_cnt_q       <= '0;
      step_q         <= '0;
      az_q           <= 1'b0;
      frame_q        <= '0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + ADDR_W'(1);
          if (clr_q == ADDR_W'(CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            sq_cnt_q <= '0;
            az_q     <= 1'b0;
            state_q  <= mode_i ? S_RD : S_SQRT;
          end
        end
        S_SQRT: begin
          sq_cnt_q <= sq_cnt_q + 4'd1;
          if (sq_cnt_q == 4'd15) begin
            step_q  <= '0;
            state_q <= S_CORD;
          end
        end
        S_CORD: begin
          if (!hold_step) begin
            step_q <= step_q + 5'd1;
            if (step_q == 5'(CORDIC_STEPS - 1)) state_q <= S_ANG;
          end
        end
        S_ANG: state_q <= S_DIV;
        S_DIV: begin
          if (!az_q) begin
            az_q    <= 1'b1;
            step_q  <= '0;
            state_q <= S_CORD;
          end else begin
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_WB;
        S_WB: begin
          if (!mode_q && eof_q && frame_q != 32'hFFFF_FFFF) frame_q <= frame_q + 32'd1;
          result_valid_o <= 1'b1;
          state_q        <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_q   <= mode_i;
          eof_q    <= end_of_frame_i;
          vx_q     <= vec_x_i;
          vy_q     <= vec_y_i;
          vz_q     <= vec_z_i;
          sq_r_q   <= sq_rem0;
          sq_res_q <= '0;
          pbin_q   <= rd_p;
          abin_q   <= rd_a;
          addr_q   <= ADDR_W'(32'(rd_p) * AZ_BINS + 32'(rd_a));
        end
      end
      S_SQRT: begin
        if (sq_r_q >= sq_trial) begin
          sq_r_q   <= sq_r_q - sq_trial;
          sq_res_q <= (sq_res_q >> 1) + sq_bit;
        end else begin
          sq_res_q <= sq_res_q >> 1;
        end
        if (sq_cnt_q == 4'd15) begin
          // the last root step lands this cycle; load the polar run next via S_CORD entry
          cz_q <= '0;
        end
      end
      S_CORD: begin
        if (hold_step) begin
          cx_q   <= ld_xs;
          cy_q   <= ld_ys;
          cz_q   <= '0;
          base_q <= ld_base;
        end else if (cy_q > 0) begin
          cx_q <= cx_q + shy;
          cy_q <= cy_q - shx;
          cz_q <= cz_q + arc;
        end else if (cy_q < 0) begin
          cx_q <= cx_q - shy;
          cy_q <= cy_q + shx;
          cz_q <= cz_q - arc;
        end
      end
      S_ANG: begin
        rem_q <= dividend;
      end
      S_DIV: begin
        if (!az_q) begin
          pbin_q <= pbin_c;
        end else begin
          abin_q <= abin_c;
          addr_q <= ADDR_W'(32'(pbin_q) * AZ_BINS + 32'(abin_c));
        end
      end
      S_WB: begin
        polar_bin_o   <= 4'(pbin_q);
        azimuth_bin_o <= 5'(abin_q);
        cell_count_o  <= out_wide[31:0];
        frames_seen_o <= (!mode_q && eof_q && frame_q != 32'hFFFF_FFFF) ?
                         frame_q + 32'd1 : frame_q;
      end
      default: ;
    endcase
  end

  // marks that the current cordic run has taken its load cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cord_loaded_q <= 1'b0;
    end else if (hold_step) begin
      cord_loaded_q <= 1'b1;
    end else if (state_q != S_CORD) begin
      cord_loaded_q <= 1'b0;
    end
  end

  // assertions
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held two cycles");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("beat accepted but block not busy");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while still busy");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for orientation_angle_histogram: directed and random beats
// depends on oah_pkg and the orientation_angle_histogram rtl
`timescale 1ns / 100ps

module tb_top;
  import oah_pkg::*;

  localparam int NBINS     = 16;
  localparam int AZ_N      = 2 * NBINS;
  localparam int CELL_N    = NBINS * AZ_N;
  localparam int N_RANDOM  = 630;
  localparam int LIMIT     = 900000;
  localparam int DRAIN     = 120;

  typedef longint unsigned u64_t;

  // beat kinds, the mode bit of one command
  typedef enum logic {MODE_ACCUM = 1'b0, MODE_READ = 1'b1} beat_mode_e;

  typedef struct {
    beat_mode_e         mode;
    logic signed [15:0] x, y, z;
    logic               eof;
    logic [3:0]         rp;
    logic [4:0]         ra;
  } orient_beat_t;

  typedef struct {
    logic [3:0]  p;
    logic [4:0]  a;
    logic [31:0] count;
    logic [31:0] frames;
  } cell_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               mode_i = 1'b0;
  logic signed [15:0] vec_x_i = '0;
  logic signed [15:0] vec_y_i = '0;
  logic signed [15:0] vec_z_i = '0;
  logic               end_of_frame_i = 1'b0;
  logic [3:0]         read_polar_index_i = '0;
  logic [4:0]         read_azimuth_index_i = '0;
  logic               result_valid_o;
  logic [3:0]         polar_bin_o;
  logic [4:0]         azimuth_bin_o;
  logic [31:0]        cell_count_o;
  logic [31:0]        frames_seen_o;

  orientation_angle_histogram #(
    .POLAR_BINS (NBINS),
    .COUNT_WIDTH(32)
  ) u_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // predictor state: own copy of the count grid and the frame counter
  // ------------------------------------------------------------------
  longint          atan_q40 [CORDIC_STEPS];
  longint unsigned grid_counts [CELL_N];
  longint unsigned frame_total;
  longint          pi_q40_l;
  cell_result_t    pending_cells [$];
  int              n_errors  = 0;
  int              n_checked = 0;
  int              n_sent    = 0;
  int              n_reads   = 0;

  // atan(2^-i) table, alternating series in q60 then down to q40
  task automatic fill_atan_table();
    longint unsigned acc;
    longint unsigned term;
    int e;
    pi_q40_l = longint'(64'h3243F6A8885A308D >> 20);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      acc = 0;
      if (i == 0) begin
        acc = 64'h3243F6A8885A308D / 4;
      end else begin
        for (int k = 0; k < 64; k++) begin
          e = 60 - i * (2 * k + 1);
          if (e >= 0) begin
            term = (64'd1 << e) / u64_t'(2 * k + 1);
            if (k % 2 == 1) acc = acc - term;
            else            acc = acc + term;
          end
        end
      end
      atan_q40[i] = longint'(acc >> 20);
    end
  endtask

  function automatic longint unsigned int_sqrt(longint unsigned r);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > r) b = b >> 2;
    while (b != 0) begin
      if (r >= res + b) begin
        r   = r - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // vectoring cordic, q40 radians; arithmetic shift of a signed value floors
  function automatic longint cordic_atan2(longint xv, longint yv);
    longint base;
    longint ang;
    longint nx, ny;
    base = 0;
    ang  = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      base = (yv >= 0) ? pi_q40_l : -pi_q40_l;
      xv = -xv;
      yv = -yv;
    end
    xv = xv * 1048576;
    yv = yv * 1048576;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (yv == 0) break;
      if (yv > 0) begin
        nx = xv + (yv >>> i);
        ny = yv - (xv >>> i);
        ang = ang + atan_q40[i];
      end else begin
        nx = xv - (yv >>> i);
        ny = yv + (xv >>> i);
        ang = ang - atan_q40[i];
      end
      xv = nx;
      yv = ny;
    end
    return base + ang;
  endfunction

  // negative angles count as bin 0, angles at or past the top edge clamp
  function automatic int angle_bin(longint ang, int last);
    longint unsigned b;
    if (ang < 0) ang = 0;
    b = (u64_t'(ang) * NBINS) / u64_t'(pi_q40_l);
    return (b > last) ? last : int'(b);
  endfunction

  // updates the predicted grid for one beat and returns the expected result
  function automatic cell_result_t bin_vector(orient_beat_t bt);
    cell_result_t r;
    int p, a, idx;
    longint zz, rem, s;
    if (bt.mode == MODE_READ) begin
      p = bt.rp;
      a = bt.ra;
      idx = p * AZ_N + a;
    end else begin
      zz  = longint'(bt.z);
      rem = (longint'(1) << 30) - zz * zz;
      s   = longint'(int_sqrt(u64_t'(rem < 0 ? 0 : rem)));
      p   = angle_bin(cordic_atan2(zz, s), NBINS - 1);
      a   = angle_bin(cordic_atan2(longint'(bt.x), longint'(bt.y)) + pi_q40_l, AZ_N - 1);
      idx = p * AZ_N + a;
      if (grid_counts[idx] < 64'hFFFF_FFFF) grid_counts[idx]++;
      if (bt.eof && frame_total < 64'hFFFF_FFFF) frame_total++;
    end
    r.p      = p[3:0];
    r.a      = a[4:0];
    r.count  = grid_counts[idx][31:0];
    r.frames = frame_total[31:0];
    return r;
  endfunction

  // ------------------------------------------------------------------
  // result checking
  // ------------------------------------------------------------------
  task automatic flag_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk_i) begin
    cell_result_t w;
    if (rst_ni && result_valid_o) begin
      if (pending_cells.size() == 0) begin
        flag_mismatch("unexpected result beat, polar", polar_bin_o, -1);
      end else begin
        w = pending_cells.pop_front();
        n_checked++;
        if (polar_bin_o   !== w.p)      flag_mismatch("polar_bin", polar_bin_o, w.p);
        if (azimuth_bin_o !== w.a)      flag_mismatch("azimuth_bin", azimuth_bin_o, w.a);
        if (cell_count_o  !== w.count)  flag_mismatch("cell_count", cell_count_o, w.count);
        if (frames_seen_o !== w.frames) flag_mismatch("frames_seen", frames_seen_o, w.frames);
      end
    end
  end

  // watchdog over the whole run
  int cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------
  // drives one command beat and holds it until the block takes it; start stays
  // high on return so a back-to-back beat needs no second assignment
  task automatic send_beat(orient_beat_t bt);
    mode_i               <= bt.mode;
    vec_x_i              <= bt.x;
    vec_y_i              <= bt.y;
    vec_z_i              <= bt.z;
    end_of_frame_i       <= bt.eof;
    read_polar_index_i   <= bt.rp;
    read_azimuth_index_i <= bt.ra;
    start                <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    pending_cells.push_back(bin_vector(bt));
    n_sent++;
    if (bt.mode == MODE_READ) n_reads++;
  endtask

  // maybe drop start for a while; long gaps now and then land deep in a busy window
  task automatic sender_gap(int pct);
    int len;
    if ($urandom_range(99) < pct) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (len) @(posedge clk_i);
    end
  endtask

  // hold off until every outstanding result is back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic orient_beat_t accum_beat(int x, int y, int z, bit eof);
    orient_beat_t bt;
    bt.mode = MODE_ACCUM;
    bt.x = 16'(x);
    bt.y = 16'(y);
    bt.z = 16'(z);
    bt.eof = eof;
    bt.rp = 4'($urandom);
    bt.ra = 5'($urandom);
    return bt;
  endfunction

  function automatic orient_beat_t read_beat(int p, int a);
    orient_beat_t bt;
    bt.mode = MODE_READ;
    bt.x = 16'($urandom);
    bt.y = 16'($urandom);
    bt.z = 16'($urandom);
    bt.eof = 1'($urandom);
    bt.rp = 4'(p);
    bt.ra = 5'(a);
    return bt;
  endfunction

  // random unit vector from random polar and azimuth angles
  function automatic orient_beat_t unit_beat(bit eof);
    real th, ph;
    th = 3.14159265358979 * $urandom_range(0, 1000000) / 1.0e6;
    ph = 3.14159265358979 * ($urandom_range(0, 2000000) / 1.0e6 - 1.0);
    return accum_beat($rtoi(32767.0 * $sin(th) * $cos(ph)),
                      $rtoi(32767.0 * $sin(th) * $sin(ph)),
                      $rtoi(32767.0 * $cos(th)), eof);
  endfunction

  // axes, pole extremes, the x=y=0 azimuth case and a non-unit vector
  task automatic test_edge_vectors();
    send_beat(read_beat(0, 0));             // never-written cell reads zero
    send_beat(accum_beat(32767, 0, 0, 0));
    send_beat(accum_beat(-32768, 0, 0, 1));
    send_beat(accum_beat(0, 32767, 0, 0));
    send_beat(accum_beat(0, -32768, 0, 0));
    send_beat(accum_beat(-32768, -1, 0, 0));  // just below the negative axis
    send_beat(accum_beat(-32768, 1, 0, 0));
    send_beat(accum_beat(0, 0, 32767, 0));    // north pole, azimuth from x=y=0
    send_beat(accum_beat(0, 0, -32768, 1));   // south pole, top polar bin
    send_beat(accum_beat(0, 0, 0, 0));
    send_beat(accum_beat(-32768, -32768, -32768, 1));
    send_beat(accum_beat(32767, 32767, 32767, 0));
    send_beat(accum_beat(-1, 0, 1, 0));
    send_beat(accum_beat(3, -7, 0, 1));       // only direction of x,y matters
    send_beat(accum_beat(0, 0, 32767, 0));    // same cell again, count 2
    drain_results();
  endtask

  // reads of the corner cells and of the cells hit above
  task automatic test_cell_reads();
    send_beat(read_beat(0, 0));
    send_beat(read_beat(15, 31));
    send_beat(read_beat(0, 31));
    send_beat(read_beat(15, 0));
    send_beat(read_beat(8, 16));
    send_beat(read_beat(7, 15));
    drain_results();
  endtask

  // mostly unit vectors, some raw noise, some reads of random cells
  task automatic test_random_mix(int n, int gap_pct);
    orient_beat_t bt;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 65)      bt = unit_beat($urandom_range(9) == 0);
      else if (sel < 82) bt = accum_beat($urandom, $urandom, $urandom, 1'($urandom));
      else               bt = read_beat($urandom_range(15), $urandom_range(31));
      send_beat(bt);
      sender_gap(gap_pct);
      if (i == n / 2) drain_results();
    end
    drain_results();
  endtask

  initial begin
    fill_atan_table();
    for (int i = 0; i < CELL_N; i++) grid_counts[i] = 0;
    frame_total = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_vectors();
    test_cell_reads();
    test_random_mix(N_RANDOM / 4, 0);
    test_random_mix(N_RANDOM / 4, 77);
    test_random_mix(N_RANDOM / 4, 6);
    test_random_mix(N_RANDOM - 3 * (N_RANDOM / 4), 0);
    test_cell_reads();

    start <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("sent %0d beats (%0d reads), checked %0d results", n_sent, n_reads, n_checked);
    $display("covered axes, poles, zero x/y, noise vectors and back-to-back and gapped beats");
    if (n_errors == 0 && pending_cells.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
